// ===== rtl/pcgsr_pkg.sv =====
// Shared constants, operation codes and control types of the PCG32 range generator.
package pcgsr_pkg;

   localparam logic [63:0] LCG_MULT     = 64'd6364136223846793005;
   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_A        = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_B        = 64'h94d049bb133111eb;
   localparam logic [63:0] ISLAND_MULT  = 64'hd1b54a32d192ed03;

   localparam logic [1:0] REQ_SEED = 2'd0;
   localparam logic [1:0] REQ_INIT = 2'd1;
   localparam logic [1:0] REQ_DRAW = 2'd2;

   typedef enum logic [3:0] {
      OP_K1,
      OP_K2,
      OP_MIX1,
      OP_MIX2,
      OP_MIX2_S0,
      OP_MIX2_S1,
      OP_ADV,
      OP_INIT,
      OP_RES_DRAW,
      OP_RES_ZERO
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
      logic   start;
      logic   exec;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic reject;
   } status_type;

endpackage

// ===== rtl/pcgsr_mul.sv =====
// Multi-cycle 64 by 64 bit multiplier that keeps the low 64 bits of the product.
module pcgsr_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] p
);

   localparam logic [1:0] PH_LL = 2'd0;
   localparam logic [1:0] PH_LH = 2'd1;
   localparam logic [1:0] PH_HL = 2'd2;

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] x;
   logic [31:0] y;
   logic [63:0] prod;

   always_comb begin
      x = a_ff[31:0];
      y = b_ff[31:0];
      case (phase_ff)
         PH_LL: begin
            x = a_ff[31:0];
            y = b_ff[31:0];
         end
         PH_LH: begin
            x = a_ff[31:0];
            y = b_ff[63:32];
         end
         PH_HL: begin
            x = a_ff[63:32];
            y = b_ff[31:0];
         end
         default: begin
            x = a_ff[31:0];
            y = b_ff[31:0];
         end
      endcase
      prod = {32'd0, x} * {32'd0, y};
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = a;
         b_in     = b;
         phase_in = PH_LL;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (phase_ff == PH_LL) begin
            acc_in = prod;
         end else begin
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         end
         if (phase_ff == PH_HL) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         phase_ff <= PH_LL;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

// ===== rtl/pcgsr_dp.sv =====
// Datapath: generator state, seeding mixer registers, range logic and result register.
module pcgsr_dp (
   input  logic                clock,
   input  logic                reset,
   input  pcgsr_pkg::cmd_type  cmd,
   output pcgsr_pkg::status_type status,
   input  logic [63:0]         req_seed_value,
   input  logic [63:0]         req_step_index,
   input  logic [63:0]         req_island_index,
   input  logic [63:0]         req_start_state,
   input  logic [63:0]         req_stream_select,
   input  logic signed [31:0]  req_range_low,
   input  logic signed [31:0]  req_range_high,
   output logic signed [31:0]  rsp_value
);

   logic [63:0] seed_ff, seed_in;
   logic [63:0] step_ff, step_in;
   logic [63:0] island_ff, island_in;
   logic [63:0] start_ff, start_in;
   logic [63:0] stream_ff, stream_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] span_ff, span_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] n_ff, n_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] w_ff, w_in;
   logic [63:0] s0_ff, s0_in;
   logic [63:0] state_ff, state_in;
   logic [63:0] inc_ff, inc_in;
   logic signed [31:0] result_ff, result_in;

   logic [31:0] span;
   logic [31:0] m;
   logic [31:0] sh;
   logic [4:0]  rot;
   logic [63:0] rr;
   logic [63:0] mix_out;
   logic [63:0] new_inc;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic        mul_done;
   logic [63:0] mul_p;

   pcgsr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   always_comb begin
      case (cmd.op)
         pcgsr_pkg::OP_K1: begin
            mul_a = step_ff;
            mul_b = pcgsr_pkg::GOLDEN_GAMMA;
         end
         pcgsr_pkg::OP_K2: begin
            mul_a = island_ff;
            mul_b = pcgsr_pkg::ISLAND_MULT;
         end
         pcgsr_pkg::OP_MIX1: begin
            mul_a = w_ff ^ (w_ff >> 30);
            mul_b = pcgsr_pkg::MIX_A;
         end
         pcgsr_pkg::OP_MIX2, pcgsr_pkg::OP_MIX2_S0, pcgsr_pkg::OP_MIX2_S1: begin
            mul_a = w_ff ^ (w_ff >> 27);
            mul_b = pcgsr_pkg::MIX_B;
         end
         default: begin
            mul_a = state_ff;
            mul_b = pcgsr_pkg::LCG_MULT;
         end
      endcase
   end

   always_comb begin
      span = req_range_high - req_range_low;
      m = span;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      sh  = state_ff[58:27] ^ {13'd0, state_ff[63:45]};
      rot = state_ff[63:59];
      rr  = {sh, sh} >> rot;
      mix_out = mul_p ^ (mul_p >> 31);
      new_inc = {mix_out[62:0], 1'b1};
   end

   always_comb begin
      seed_in   = seed_ff;
      step_in   = step_ff;
      island_in = island_ff;
      start_in  = start_ff;
      stream_in = stream_ff;
      lo_in     = lo_ff;
      span_in   = span_ff;
      mask_in   = mask_ff;
      n_in      = n_ff;
      t_in      = t_ff;
      w_in      = w_ff;
      s0_in     = s0_ff;
      state_in  = state_ff;
      inc_in    = inc_ff;
      result_in = result_ff;
      if (cmd.load) begin
         seed_in   = req_seed_value;
         step_in   = req_step_index;
         island_in = req_island_index;
         start_in  = req_start_state;
         stream_in = req_stream_select;
         lo_in     = req_range_low;
         span_in   = span;
         mask_in   = m;
      end
      if (cmd.start && cmd.op == pcgsr_pkg::OP_ADV) begin
         n_in = rr[31:0] & mask_ff;
      end
      if (mul_done) begin
         case (cmd.op)
            pcgsr_pkg::OP_K1: t_in = seed_ff + mul_p;
            pcgsr_pkg::OP_K2: w_in = t_ff + mul_p + pcgsr_pkg::GOLDEN_GAMMA;
            pcgsr_pkg::OP_MIX1: w_in = mul_p;
            pcgsr_pkg::OP_MIX2: w_in = mix_out + pcgsr_pkg::GOLDEN_GAMMA;
            pcgsr_pkg::OP_MIX2_S0: begin
               s0_in = mix_out;
               w_in  = mix_out + pcgsr_pkg::GOLDEN_GAMMA;
            end
            pcgsr_pkg::OP_MIX2_S1: begin
               inc_in   = new_inc;
               state_in = new_inc + s0_ff;
            end
            pcgsr_pkg::OP_ADV: state_in = mul_p + inc_ff;
            default: state_in = state_ff;
         endcase
      end
      if (cmd.exec) begin
         case (cmd.op)
            pcgsr_pkg::OP_INIT: begin
               inc_in   = {stream_ff[62:0], 1'b1};
               state_in = {stream_ff[62:0], 1'b1} + start_ff;
            end
            pcgsr_pkg::OP_RES_DRAW: result_in = $signed(n_ff + lo_ff);
            default: result_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      seed_ff   <= seed_in;
      step_ff   <= step_in;
      island_ff <= island_in;
      start_ff  <= start_in;
      stream_ff <= stream_in;
      lo_ff     <= lo_in;
      span_ff   <= span_in;
      mask_ff   <= mask_in;
      n_ff      <= n_in;
      t_ff      <= t_in;
      w_ff      <= w_in;
      s0_ff     <= s0_in;
      result_ff <= result_in;
      if (reset) begin
         state_ff <= '0;
         inc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         inc_ff   <= inc_in;
      end
   end

   assign status.mul_done = mul_done;
   assign status.reject   = n_ff > span_ff;
   assign rsp_value       = result_ff;

endmodule

// ===== rtl/pcgsr_ctrl.sv =====
// Controller: sequences seeding, initialization and draw requests and owns the handshakes.
module pcgsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pcgsr_pkg::cmd_type    cmd,
   input  pcgsr_pkg::status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_LAUNCH,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   pcgsr_pkg::op_type op_ff, op_in;
   logic [1:0]        kind_ff, kind_in;
   logic [1:0]        mix_ff, mix_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              finish;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == S_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      kind_in  = kind_ff;
      mix_in   = mix_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_type;
               mix_in  = 2'd0;
               case (req_type)
                  pcgsr_pkg::REQ_SEED: begin
                     op_in    = pcgsr_pkg::OP_K1;
                     state_in = S_LAUNCH;
                  end
                  pcgsr_pkg::REQ_INIT: begin
                     op_in    = pcgsr_pkg::OP_INIT;
                     state_in = S_INIT;
                  end
                  pcgsr_pkg::REQ_DRAW: begin
                     op_in    = pcgsr_pkg::OP_ADV;
                     state_in = S_LAUNCH;
                  end
                  default: begin
                     op_in    = pcgsr_pkg::OP_RES_ZERO;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_INIT: begin
            op_in    = pcgsr_pkg::OP_ADV;
            state_in = S_LAUNCH;
         end
         S_LAUNCH: state_in = S_WAIT;
         S_WAIT: begin
            if (status.mul_done) begin
               state_in = S_LAUNCH;
               case (op_ff)
                  pcgsr_pkg::OP_K1: op_in = pcgsr_pkg::OP_K2;
                  pcgsr_pkg::OP_K2: op_in = pcgsr_pkg::OP_MIX1;
                  pcgsr_pkg::OP_MIX1: begin
                     case (mix_ff)
                        2'd0: op_in = pcgsr_pkg::OP_MIX2;
                        2'd1: op_in = pcgsr_pkg::OP_MIX2_S0;
                        default: op_in = pcgsr_pkg::OP_MIX2_S1;
                     endcase
                  end
                  pcgsr_pkg::OP_MIX2, pcgsr_pkg::OP_MIX2_S0: begin
                     mix_in = mix_ff + 2'd1;
                     op_in  = pcgsr_pkg::OP_MIX1;
                  end
                  pcgsr_pkg::OP_MIX2_S1: op_in = pcgsr_pkg::OP_ADV;
                  pcgsr_pkg::OP_ADV: begin
                     if (kind_ff != pcgsr_pkg::REQ_DRAW) begin
                        op_in    = pcgsr_pkg::OP_RES_ZERO;
                        state_in = S_FINISH;
                     end else if (!status.reject) begin
                        op_in    = pcgsr_pkg::OP_RES_DRAW;
                        state_in = S_FINISH;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= pcgsr_pkg::OP_RES_ZERO;
         kind_ff      <= pcgsr_pkg::REQ_SEED;
         mix_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         kind_ff      <= kind_in;
         mix_ff       <= mix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.op    = op_ff;
   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.start = (state_ff == S_LAUNCH);
   assign cmd.exec  = (state_ff == S_INIT) || finish;

endmodule

// ===== rtl/pcg32_seeded_range_generator.sv =====
// Top level of the PCG32 generator with tuple seeding and ranged signed draws.
//
// Requests arrive on the req_ channel as valid/ready transfers; req_type selects
// seeding from a (seed, step, island) tuple, direct initialization from a start
// state and stream, or a draw in [req_range_low, req_range_high]. Every request
// gives exactly one transfer on the rsp_ channel; seeding requests return zero.
// One request is processed at a time. Every 64-bit multiply runs on one shared
// 32 by 32 multiplier, which forms the low-low, low-high and high-low partial
// products in turn. A draw repeats generator steps until the masked output is
// within the span; the number of steps taken averages under two with rejection.
// Direct initialization and tuple seeding each end with one generator step; the
// unused request code returns zero. The next request is accepted in the cycle after
// the result is loaded into the output register, even while that result still
// waits for rsp_ready; a stalled receiver holds the block only when a second
// result is ready to be loaded. Reset clears the generator state and increment
// to zero, so draws before any seeding return req_range_low.
module pcg32_seeded_range_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [63:0]        req_seed_value,
   input  logic [63:0]        req_step_index,
   input  logic [63:0]        req_island_index,
   input  logic [63:0]        req_start_state,
   input  logic [63:0]        req_stream_select,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value
);

   pcgsr_pkg::cmd_type    cmd;
   pcgsr_pkg::status_type status;

   pcgsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pcgsr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_seed_value    (req_seed_value),
      .req_step_index    (req_step_index),
      .req_island_index  (req_island_index),
      .req_start_state   (req_start_state),
      .req_stream_select (req_stream_select),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .rsp_value         (rsp_value)
   );

endmodule
